// ===== sv/twc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg
// Shared constants and types of the triangle window clipper.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 20;
  localparam int CFG_W     = 13;
  localparam int MAX_VERTS = 7;
  localparam int VBUF      = 8;
  localparam int IDX_W     = $clog2(VBUF);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);
  localparam int BOUND_W   = CFG_W + 1 + FRAC_BITS;
  localparam int CW        = ((COORD_W > BOUND_W) ? COORD_W : BOUND_W) + 3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] ax;
  } tri_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] d;
  } div_req_t;

endpackage

// ===== sv/triangle_window_clipper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_window_clipper
// Clips one triangle per item to the window and streams the polygon vertices.
// ----------------------------------------------------------------------------
// Sequence: each pass has a setup state, then each vertex is read and stepped;
//   an edge crossing adds a serial multiply and divide, and an entering edge
//   adds one more push of the vertex itself.
// Throughput: one triangle in the engine; a queued one starts the cycle after the
//   last vertex is issued. A two-entry queue keeps accepting meanwhile until full.
// Reset: queue and engine go empty, width 640 and height 480.
module triangle_window_clipper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [6*twc_pkg::COORD_W-1:0] s_axis_tdata, // ax, ay, bx, by_coord, cx, cy
  input  logic                 s_axis_tuser,          // hidden
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*twc_pkg::COORD_W-1:0] m_axis_tdata, // vertex_x, vertex_y
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [twc_pkg::CFG_W-1:0] cfg_data
);
  import twc_pkg::*;

  logic [CFG_W-1:0] window_width;
  logic [CFG_W-1:0] window_height;
  logic             q_valid;
  tri_t             q_tri;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= CFG_W'(640);
      window_height <= CFG_W'(480);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        window_width <= cfg_data;
      end else if (cfg_index == REG_HEIGHT) begin
        window_height <= cfg_data;
      end
    end
  end

  twc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (tri_t'(s_axis_tdata)),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_tri         (q_tri),
    .q_pop         (q_pop)
  );

  twc_clip u_clip (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_tri         (q_tri),
    .q_pop         (q_pop),
    .window_width  (window_width),
    .window_height (window_height),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== sv/twc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_front
// Accepts triangles, drops hidden ones, queues the rest for the clip engine.
// ----------------------------------------------------------------------------
module twc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  twc_pkg::tri_t s_axis_tdata,
  input  logic          s_axis_tuser,
  output logic          q_valid,
  output twc_pkg::tri_t q_tri,
  input  logic          q_pop
);
  import twc_pkg::*;

  tri_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
  assign q_valid       = (count != 2'd0);
  assign q_tri         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== sv/twc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_div
// Serial multiply then restoring divide: trunc(a * b / d), zero when d is 0.
// ----------------------------------------------------------------------------
module twc_div (
  input  logic              clk,
  input  logic              rst,
  input  twc_pkg::div_req_t req,
  output logic              done,
  output logic signed [twc_pkg::CW-1:0] quot
);
  import twc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam int         CNT_BW  = $clog2(2 * CW);

  logic [1:0]        st;
  logic [2*CW-1:0]   ma;
  logic [CW-1:0]     mb;
  logic [CW-1:0]     md;
  logic [2*CW-1:0]   acc;
  logic [CW-1:0]     rem;
  logic [CNT_BW-1:0] cnt;
  logic              neg;
  logic              zden;
  logic [CW:0]       trial;
  logic [CW-1:0]     qmag;

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  assign trial = {rem, acc[2*CW-1]};
  assign qmag  = acc[CW-1:0];
  assign done  = (st == ST_FIN);
  assign quot  = zden ? '0 : (neg ? $signed(CW'(-qmag)) : $signed(qmag));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: begin
          if (req.start) begin
            st   <= ST_MUL;
            ma   <= {{CW{1'b0}}, mag(req.a)};
            mb   <= mag(req.b);
            md   <= mag(req.d);
            neg  <= req.a[CW-1] ^ req.b[CW-1] ^ req.d[CW-1];
            zden <= (req.d == '0);
            acc  <= '0;
            cnt  <= '0;
          end
        end
        ST_MUL: begin
          if (mb[0]) begin
            acc <= acc + ma;
          end
          ma  <= ma << 1;
          mb  <= mb >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BW'(CW - 1)) begin
            st  <= ST_DIV;
            cnt <= '0;
            rem <= '0;
          end
        end
        ST_DIV: begin
          if (trial >= {1'b0, md}) begin
            rem <= CW'(trial - {1'b0, md});
            acc <= {acc[2*CW-2:0], 1'b1};
          end else begin
            rem <= trial[CW-1:0];
            acc <= {acc[2*CW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BW'(2 * CW - 1)) begin
            st <= ST_FIN;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/twc_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_clip
// Four Sutherland-Hodgman passes with rotation, then vertex output.
// ----------------------------------------------------------------------------
module twc_clip (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  twc_pkg::tri_t             q_tri,
  output logic                      q_pop,
  input  logic [twc_pkg::CFG_W-1:0] window_width,
  input  logic [twc_pkg::CFG_W-1:0] window_height,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [2*twc_pkg::COORD_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import twc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_PUSHP = 3'd4;
  localparam logic [2:0] ST_STEP  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]       st;
  vtx_t             buf_a [VBUF];
  vtx_t             buf_b [VBUF];
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic [1:0]       pass;
  vtx_t             s;
  vtx_t             p;
  logic             p_in_r;
  vtx_t             src_v;
  logic signed [CW-1:0] bound;
  logic [CFG_W-1:0] wsel;
  logic             p_in;
  logic             s_in;
  div_req_t         dreq;
  logic             ddone;
  logic signed [CW-1:0] dquot;
  logic             push;
  vtx_t             push_v;
  logic             out_free;
  logic             emit_fire;
  vtx_t             emit_v;

  assign wsel  = pass[0] ? window_height : window_width;
  assign bound = pass[1] ? $signed((CW'(1) - CW'(wsel)) << FRAC_BITS)
                         : $signed(CW'(1) << FRAC_BITS);
  assign src_v = pass[0] ? buf_b[idx] : buf_a[idx];
  assign p_in  = (src_v.x >= bound);
  assign s_in  = (s.x >= bound);
  assign emit_v = buf_a[idx];
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit_fire = (st == ST_EMIT) && (n != '0) && out_free;
  assign q_pop = (st == ST_IDLE) && q_valid;

  assign dreq.start = (st == ST_READ) && (p_in != s_in);
  assign dreq.a     = bound - s.x;
  assign dreq.b     = src_v.y - s.y;
  assign dreq.d     = src_v.x - s.x;

  twc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dquot)
  );

  always_comb begin
    push   = 1'b0;
    push_v = p;
    case (st)
      ST_READ: begin
        push   = p_in && s_in;
        push_v = src_v;
      end
      ST_WAIT: begin
        push     = ddone;
        push_v.x = bound;
        push_v.y = s.y + dquot;
      end
      ST_PUSHP: begin
        push = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push && cnt < CNT_W'(MAX_VERTS)) begin
      if (pass[0]) begin
        buf_a[cnt[IDX_W-1:0]] <= '{x: push_v.y, y: -push_v.x};
      end else begin
        buf_b[cnt[IDX_W-1:0]] <= '{x: push_v.y, y: -push_v.x};
      end
    end else if (q_pop) begin
      buf_a[0] <= '{x: CW'(q_tri.ax), y: CW'(q_tri.ay)};
      buf_a[1] <= '{x: CW'(q_tri.bx), y: CW'(q_tri.by_coord)};
      buf_a[2] <= '{x: CW'(q_tri.cx), y: CW'(q_tri.cy)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      n             <= '0;
      cnt           <= '0;
      idx           <= '0;
      pass          <= '0;
    end else begin
      if (emit_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (push && cnt < CNT_W'(MAX_VERTS)) begin
        cnt <= cnt + 1'b1;
      end
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            n    <= CNT_W'(3);
            pass <= '0;
            st   <= ST_START;
          end
        end
        ST_START: begin
          cnt <= '0;
          if (n == '0) begin
            st <= ST_IDLE;
          end else begin
            idx <= '0;
            st  <= ST_READ;
          end
        end
        ST_READ: begin
          p      <= src_v;
          p_in_r <= p_in;
          if (p_in != s_in) begin
            st <= ST_WAIT;
          end else begin
            st <= ST_STEP;
          end
        end
        ST_WAIT: begin
          if (ddone) begin
            st <= p_in_r ? ST_PUSHP : ST_STEP;
          end
        end
        ST_PUSHP: begin
          st <= ST_STEP;
        end
        ST_STEP: begin
          s <= p;
          if (idx == IDX_W'(n - 1'b1)) begin
            n    <= cnt;
            idx  <= '0;
            pass <= pass + 1'b1;
            st   <= (pass == 2'd3) ? ST_EMIT : ST_START;
          end else begin
            idx <= idx + 1'b1;
            st  <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (n == '0) begin
            st <= ST_IDLE;
          end else if (out_free) begin
            m_axis_tdata  <= {emit_v.y[COORD_W-1:0], emit_v.x[COORD_W-1:0]};
            m_axis_tlast  <= (idx == IDX_W'(n - 1'b1));
            if (idx == IDX_W'(n - 1'b1)) begin
              st <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
      if (st == ST_START && n != '0) begin
        s <= pass[0] ? buf_b[IDX_W'(n - 1'b1)] : buf_a[IDX_W'(n - 1'b1)];
      end
    end
  end

endmodule

// ===== sv/twc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_checker
// Port-level checks of the triangle window clipper.
// ----------------------------------------------------------------------------
module twc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind triangle_window_clipper twc_checker u_twc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
